// ===== hdl/evp_pkg.sv =====
// Shared widths, types and helpers for the Euler rotate / project vertex unit.
// Used by every module in hdl/; depends on nothing.
package evp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int TRIG_WIDTH  = 18;
  localparam int TRIG_FRAC   = TRIG_WIDTH - 2;
  localparam int TRIG_ONE    = 1 << TRIG_FRAC;
  localparam int ID_WIDTH    = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int ZOOM_WIDTH  = 24;
  localparam int ZOOM_FRAC   = 16;
  localparam int ZOOM_RESET  = 1 << ZOOM_FRAC;

  // Rotation operands grow by under three bits through the three rotations
  localparam int ROT_W   = COORD_WIDTH + 4;
  localparam int PROD_W  = ROT_W + TRIG_WIDTH;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ZPROD_W = ROT_W + ZOOM_WIDTH + 1;
  localparam int SAT_W   = ZPROD_W + 2;

  localparam int TDATA_W = ((ID_WIDTH + 3 * COORD_WIDTH + 7) / 8) * 8;

  localparam int NUM_REGS  = 6;
  localparam int CFG_DW    = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int CFG_LSB   = (CFG_DW == 64) ? 3 : 2;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_AW    = REG_IDX_W + CFG_LSB;

  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_K     = 652032874;
  localparam int CORDIC_W     = CORDIC_FRAC + 2;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_YAW   = 0,
    REG_PITCH = 1,
    REG_ROLL  = 2,
    REG_ZOOM  = 3,
    REG_OFFX  = 4,
    REG_OFFY  = 5
  } reg_idx_t;

  typedef enum logic [1:0] {
    AX_YAW   = 2'd0,
    AX_PITCH = 2'd1,
    AX_ROLL  = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [TRIG_WIDTH-1:0] c;
    logic signed [TRIG_WIDTH-1:0] s;
  } trig_pair_t;

  // angle registers plus a write strobe per axis
  typedef struct packed {
    logic [2:0]                  wr;
    logic [2:0][ANGLE_WIDTH-1:0] angle;
  } angle_cfg_t;

  // word moving between rotation stages
  typedef struct packed {
    logic [ID_WIDTH-1:0]     id;
    logic signed [ROT_W-1:0] a;
    logic signed [ROT_W-1:0] b;
    logic signed [ROT_W-1:0] side;
  } rot_word_t;

  // arctan(2^-i) in binary angle units, quarter turn = 2^CORDIC_FRAC
  function automatic logic [CORDIC_FRAC-1:0] atan_lut(logic [STEP_W-1:0] i);
    logic [CORDIC_FRAC-1:0] v;
    case (i)
      5'd0:    v = CORDIC_FRAC'(536870912);
      5'd1:    v = CORDIC_FRAC'(316933406);
      5'd2:    v = CORDIC_FRAC'(167458907);
      5'd3:    v = CORDIC_FRAC'(85004756);
      5'd4:    v = CORDIC_FRAC'(42667331);
      5'd5:    v = CORDIC_FRAC'(21354465);
      5'd6:    v = CORDIC_FRAC'(10679838);
      5'd7:    v = CORDIC_FRAC'(5340245);
      5'd8:    v = CORDIC_FRAC'(2670163);
      5'd9:    v = CORDIC_FRAC'(1335087);
      5'd10:   v = CORDIC_FRAC'(667544);
      5'd11:   v = CORDIC_FRAC'(333772);
      5'd12:   v = CORDIC_FRAC'(166886);
      5'd13:   v = CORDIC_FRAC'(83443);
      5'd14:   v = CORDIC_FRAC'(41722);
      5'd15:   v = CORDIC_FRAC'(20861);
      5'd16:   v = CORDIC_FRAC'(10430);
      5'd17:   v = CORDIC_FRAC'(5215);
      5'd18:   v = CORDIC_FRAC'(2608);
      5'd19:   v = CORDIC_FRAC'(1304);
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a wide signed value into the coordinate range
  function automatic logic [COORD_WIDTH-1:0] sat_coord(logic signed [SAT_W-1:0] v);
    logic [SAT_W-COORD_WIDTH:0] hi;
    logic [COORD_WIDTH-1:0]     r;
    hi = v[SAT_W-1:COORD_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      r = v[COORD_WIDTH-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/evp_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on evp_pkg; feeds angles to evp_trig, zoom and offsets to evp_project.
module evp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [evp_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [evp_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [evp_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready,
  output evp_pkg::angle_cfg_t            ang_o,
  output logic [evp_pkg::ZOOM_WIDTH-1:0] zoom_o,
  output logic [evp_pkg::COORD_WIDTH-1:0] offx_o,
  output logic [evp_pkg::COORD_WIDTH-1:0] offy_o
);
  import evp_pkg::*;

  logic [2:0][ANGLE_WIDTH-1:0] angle_r;
  logic [ZOOM_WIDTH-1:0]       zoom_r;
  logic [COORD_WIDTH-1:0]      offx_r;
  logic [COORD_WIDTH-1:0]      offy_r;
  logic                        wr_en;
  reg_idx_t                    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:CFG_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      zoom_r  <= ZOOM_WIDTH'(ZOOM_RESET);
      offx_r  <= '0;
      offy_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_YAW:   angle_r[AX_YAW]   <= cfg_pwdata[ANGLE_WIDTH-1:0];
        REG_PITCH: angle_r[AX_PITCH] <= cfg_pwdata[ANGLE_WIDTH-1:0];
        REG_ROLL:  angle_r[AX_ROLL]  <= cfg_pwdata[ANGLE_WIDTH-1:0];
        REG_ZOOM:  zoom_r <= cfg_pwdata[ZOOM_WIDTH-1:0];
        REG_OFFX:  offx_r <= cfg_pwdata[COORD_WIDTH-1:0];
        REG_OFFY:  offy_r <= cfg_pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ang_o.angle = angle_r;
    ang_o.wr    = '0;
    cfg_prdata  = '0;
    case (idx)
      REG_YAW: begin
        ang_o.wr[AX_YAW] = wr_en;
        cfg_prdata       = CFG_DW'(angle_r[AX_YAW]);
      end
      REG_PITCH: begin
        ang_o.wr[AX_PITCH] = wr_en;
        cfg_prdata         = CFG_DW'(angle_r[AX_PITCH]);
      end
      REG_ROLL: begin
        ang_o.wr[AX_ROLL] = wr_en;
        cfg_prdata        = CFG_DW'(angle_r[AX_ROLL]);
      end
      REG_ZOOM: cfg_prdata = CFG_DW'(zoom_r);
      REG_OFFX: cfg_prdata = CFG_DW'(offx_r);
      REG_OFFY: cfg_prdata = CFG_DW'(offy_r);
      default:  cfg_prdata = '0;
    endcase
  end

  assign zoom_o = zoom_r;
  assign offx_o = offx_r;
  assign offy_o = offy_r;

endmodule

// ===== hdl/evp_trig.sv =====
// Iterative CORDIC that turns each written angle into a cos/sin pair, and the
// three-entry trig store (one cos/sin pair per axis) read by the rotation stages. Depends on evp_pkg.
module evp_trig (
  input  logic                clk,
  input  logic                rst_n,
  input  evp_pkg::angle_cfg_t ang_i,
  output evp_pkg::trig_pair_t trig_o [3],
  output logic                busy_o
);
  import evp_pkg::*;

  typedef enum logic [2:0] {
    TRG_IDLE = 3'b001,
    TRG_RUN  = 3'b010,
    TRG_DONE = 3'b100
  } trg_state_t;

  localparam logic [1:0] QUAD_1 = 2'd0;
  localparam logic [1:0] QUAD_2 = 2'd1;
  localparam logic [1:0] QUAD_3 = 2'd2;
  localparam logic [1:0] QUAD_4 = 2'd3;
  localparam int RND_SH   = CORDIC_FRAC - TRIG_FRAC;
  localparam int RND_HALF = 1 << (RND_SH - 1);
  localparam int RES_W    = ANGLE_WIDTH - 2;

  trg_state_t                  state_r, state_nxt;
  logic [2:0]                  pend_r, pend_nxt;
  axis_t                       axis_r, axis_nxt, pick;
  logic [1:0]                  quad_r, quad_nxt;
  logic                        zero_r, zero_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic signed [CORDIC_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CORDIC_W-1:0]  dx, dy, at;
  logic [ANGLE_WIDTH-1:0]      ang;
  logic signed [TRIG_WIDTH-1:0] c_rnd, s_rnd;
  trig_pair_t                  pair;
  trig_pair_t                  trig_r [3];
  trig_pair_t                  trig_nxt [3];
  logic                        store_ok;

  function automatic logic signed [TRIG_WIDTH-1:0] trig_round(
    logic signed [CORDIC_W-1:0] v
  );
    logic signed [CORDIC_W:0] t;
    logic signed [CORDIC_W:0] one;
    t   = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(RND_HALF);
    t   = t >>> RND_SH;
    one = (CORDIC_W+1)'(TRIG_ONE);
    if (t > one) begin
      t = one;
    end else if (t < -one) begin
      t = -one;
    end
    return t[TRIG_WIDTH-1:0];
  endfunction

  always_comb begin
    if (pend_r[AX_YAW]) begin
      pick = AX_YAW;
    end else if (pend_r[AX_PITCH]) begin
      pick = AX_PITCH;
    end else begin
      pick = AX_ROLL;
    end
    ang = ang_i.angle[pick];

    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = CORDIC_W'(atan_lut(step_r));

    // residual of exactly zero skips the iterations
    if (zero_r) begin
      c_rnd = TRIG_WIDTH'(TRIG_ONE);
      s_rnd = '0;
    end else begin
      c_rnd = trig_round(x_r);
      s_rnd = trig_round(y_r);
    end
    case (quad_r)
      QUAD_1: begin pair.c = c_rnd;  pair.s = s_rnd;  end
      QUAD_2: begin pair.c = -s_rnd; pair.s = c_rnd;  end
      QUAD_3: begin pair.c = -c_rnd; pair.s = -s_rnd; end
      QUAD_4: begin pair.c = s_rnd;  pair.s = -c_rnd; end
      default: begin pair.c = c_rnd; pair.s = s_rnd; end
    endcase

    state_nxt = state_r;
    pend_nxt  = pend_r;
    axis_nxt  = axis_r;
    quad_nxt  = quad_r;
    zero_nxt  = zero_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    trig_nxt  = trig_r;

    case (state_r)
      TRG_IDLE: begin
        if (|pend_r) begin
          pend_nxt[pick] = 1'b0;
          axis_nxt  = pick;
          quad_nxt  = ang[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
          zero_nxt  = !(|ang[RES_W-1:0]);
          step_nxt  = '0;
          x_nxt     = CORDIC_W'(CORDIC_K);
          y_nxt     = '0;
          z_nxt     = CORDIC_W'(ang[RES_W-1:0]) <<< (CORDIC_FRAC - RES_W);
          state_nxt = zero_nxt ? TRG_DONE : TRG_RUN;
        end
      end
      TRG_RUN: begin
        if (!z_r[CORDIC_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = TRG_DONE;
        end
      end
      TRG_DONE: begin
        trig_nxt[axis_r] = pair;
        state_nxt        = TRG_IDLE;
      end
      default: state_nxt = TRG_IDLE;
    endcase

    // a fresh write re-queues its axis, even if that axis is in flight
    pend_nxt = pend_nxt | ang_i.wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRG_IDLE;
      pend_r  <= '0;
      step_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        trig_r[k].c <= TRIG_WIDTH'(TRIG_ONE);
        trig_r[k].s <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      step_r  <= step_nxt;
      trig_r  <= trig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    quad_r <= quad_nxt;
    zero_r <= zero_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign trig_o = trig_r;
  assign busy_o = (state_r != TRG_IDLE) || (|pend_r) || (|ang_i.wr);

  always_comb begin
    store_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (trig_r[k].c > TRIG_WIDTH'(TRIG_ONE) || trig_r[k].c < -TRIG_WIDTH'(TRIG_ONE) ||
          trig_r[k].s > TRIG_WIDTH'(TRIG_ONE) || trig_r[k].s < -TRIG_WIDTH'(TRIG_ONE)) begin
        store_ok = 1'b0;
      end
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == TRG_DONE |=> state_r == TRG_IDLE)
    else $error("trig engine did not return to idle after store write");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == TRG_RUN && step_r == STEP_W'(CORDIC_STEPS - 1) |=> state_r == TRG_DONE)
    else $error("trig engine ran past its last step");

  a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
    store_ok)
    else $error("trig store holds a value outside [-1, 1]");

endmodule

// ===== hdl/evp_rotate.sv =====
// One planar rotation, two register stages: four products, then sum and round.
// Maps (a, b) to (a*c - b*s, a*s + b*c); side word rides along. Depends on evp_pkg.
module evp_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  evp_pkg::rot_word_t  in_word,
  input  evp_pkg::trig_pair_t trig_i,
  output logic                out_valid,
  input  logic                out_ready,
  output evp_pkg::rot_word_t  out_word
);
  import evp_pkg::*;

  localparam int RND_HALF = 1 << (TRIG_FRAC - 1);

  logic                     va_r, vb_r, en_a, en_b;
  logic [ID_WIDTH-1:0]      id_a_r;
  logic signed [ROT_W-1:0]  side_a_r;
  logic signed [PROD_W-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [PROD_W-1:0] pac_nxt, pbs_nxt, pas_nxt, pbc_nxt;
  logic signed [SUM_W-1:0]  sum_p, sum_q;
  rot_word_t                out_r, out_nxt;

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    pac_nxt = $signed(in_word.a) * $signed(trig_i.c);
    pbs_nxt = $signed(in_word.b) * $signed(trig_i.s);
    pas_nxt = $signed(in_word.a) * $signed(trig_i.s);
    pbc_nxt = $signed(in_word.b) * $signed(trig_i.c);
  end

  always_comb begin
    sum_p = SUM_W'(pac_r) - SUM_W'(pbs_r) + SUM_W'(RND_HALF);
    sum_q = SUM_W'(pas_r) + SUM_W'(pbc_r) + SUM_W'(RND_HALF);
    sum_p = sum_p >>> TRIG_FRAC;
    sum_q = sum_q >>> TRIG_FRAC;
    out_nxt.id   = id_a_r;
    out_nxt.a    = sum_p[ROT_W-1:0];
    out_nxt.b    = sum_q[ROT_W-1:0];
    out_nxt.side = side_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      id_a_r   <= in_word.id;
      side_a_r <= in_word.side;
      pac_r    <= pac_nxt;
      pbs_r    <= pbs_nxt;
      pas_r    <= pas_nxt;
      pbc_r    <= pbc_nxt;
    end
    if (en_b) out_r <= out_nxt;
  end

  assign out_valid = vb_r;
  assign out_word  = out_r;

  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && vb_r && !out_ready |=> va_r && $stable(id_a_r) && $stable(pac_r))
    else $error("product stage overwritten while blocked");

endmodule

// ===== hdl/evp_project.sv =====
// Zoom, page offset and saturation: a product stage and the output register.
// Depends on evp_pkg; takes the roll stage word (x, y, depth in side).
module evp_project (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  evp_pkg::rot_word_t                  in_word,
  input  logic [evp_pkg::ZOOM_WIDTH-1:0]      zoom,
  input  logic signed [evp_pkg::COORD_WIDTH-1:0] offx,
  input  logic signed [evp_pkg::COORD_WIDTH-1:0] offy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [evp_pkg::ID_WIDTH-1:0]        out_id,
  output logic [evp_pkg::COORD_WIDTH-1:0]     out_px,
  output logic [evp_pkg::COORD_WIDTH-1:0]     out_py,
  output logic [evp_pkg::COORD_WIDTH-1:0]     out_depth
);
  import evp_pkg::*;

  localparam int ZHALF = 1 << (ZOOM_FRAC - 1);

  logic                        va_r, vb_r, en_a, en_b;
  logic signed [ZOOM_WIDTH:0]  zm;
  logic signed [ZPROD_W-1:0]   mx_r, my_r, mx_nxt, my_nxt;
  logic [ID_WIDTH-1:0]         id_a_r, id_b_r;
  logic [COORD_WIDTH-1:0]      depth_a_r, depth_b_r;
  logic [COORD_WIDTH-1:0]      px_r, py_r;
  logic signed [SAT_W-1:0]     sx, sy;

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;
  assign zm       = $signed({1'b0, zoom});

  always_comb begin
    mx_nxt = $signed(in_word.a) * zm;
    my_nxt = $signed(in_word.b) * zm;
  end

  always_comb begin
    sx = (SAT_W'(mx_r) + SAT_W'(ZHALF)) >>> ZOOM_FRAC;
    sy = (SAT_W'(my_r) + SAT_W'(ZHALF)) >>> ZOOM_FRAC;
    sx = sx + SAT_W'(offx);
    sy = sy + SAT_W'(offy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      id_a_r    <= in_word.id;
      mx_r      <= mx_nxt;
      my_r      <= my_nxt;
      depth_a_r <= sat_coord(SAT_W'($signed(in_word.side)));
    end
    if (en_b) begin
      id_b_r    <= id_a_r;
      depth_b_r <= depth_a_r;
      px_r      <= sat_coord(sx);
      py_r      <= sat_coord(sy);
    end
  end

  assign out_valid = vb_r;
  assign out_id    = id_b_r;
  assign out_px    = px_r;
  assign out_py    = py_r;
  assign out_depth = depth_b_r;

endmodule

// ===== hdl/euler_rotate_project_vertex_unit.sv =====
// Top level: vertex stream in, rotated and projected vertex stream out.
// Instantiates evp_regs, evp_trig, three evp_rotate stages and evp_project.
//
//  port group  dir      handshake                fields (tdata, low bit up)
//  in_*        slave    in_tvalid / in_tready    vertex_id, pos_x, pos_y, pos_z
//  out_*       master   out_tvalid / out_tready  out_id, page_x, page_y, depth
//  cfg_*       APB      psel+penable, pready=1   yaw, pitch, roll, zoom, offx, offy
//
// One word per cycle while in_tready is high; eight register stages (two per rotation,
// two for zoom and offset). Each angle write runs the CORDIC, which skips the
// iterations for a whole-quadrant angle; in_tready stays low until every queued angle
// is done. Reset is synchronous; it restores cos 1 / sin 0 at once. A stall on
// out_tready holds each stage only where its successor is full, so bubbles still close up.
module euler_rotate_project_vertex_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [evp_pkg::TDATA_W-1:0]  in_tdata,   // vertex_id, pos_x, pos_y, pos_z
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [evp_pkg::TDATA_W-1:0]  out_tdata,  // out_id, page_x, page_y, depth
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [evp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [evp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [evp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import evp_pkg::*;

  angle_cfg_t             ang;
  logic [ZOOM_WIDTH-1:0]  zoom;
  logic [COORD_WIDTH-1:0] offx, offy;
  trig_pair_t             trig [3];
  logic                   trig_busy;

  rot_word_t yaw_in, yaw_out, pit_in, pit_out, rol_in, rol_out;
  logic      yaw_vi, yaw_ri, yaw_vo, pit_ri, pit_vo, rol_ri, rol_vo, prj_ri;

  logic [ID_WIDTH-1:0]    res_id;
  logic [COORD_WIDTH-1:0] res_px, res_py, res_depth;

  evp_regs u_regs (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .ang_o  (ang),
    .zoom_o (zoom),
    .offx_o (offx),
    .offy_o (offy)
  );

  evp_trig u_trig (
    .clk, .rst_n,
    .ang_i  (ang),
    .trig_o (trig),
    .busy_o (trig_busy)
  );

  // yaw: (z, x) -> (yaw_z, yaw_x), y rides along
  always_comb begin
    yaw_in.id   = in_tdata[ID_WIDTH-1:0];
    yaw_in.b    = ROT_W'($signed(in_tdata[ID_WIDTH +: COORD_WIDTH]));
    yaw_in.side = ROT_W'($signed(in_tdata[ID_WIDTH + COORD_WIDTH +: COORD_WIDTH]));
    yaw_in.a    = ROT_W'($signed(in_tdata[ID_WIDTH + 2 * COORD_WIDTH +: COORD_WIDTH]));
  end

  assign yaw_vi    = in_tvalid && !trig_busy;
  assign in_tready = yaw_ri && !trig_busy;

  evp_rotate u_yaw (
    .clk, .rst_n,
    .in_valid  (yaw_vi),
    .in_ready  (yaw_ri),
    .in_word   (yaw_in),
    .trig_i    (trig[AX_YAW]),
    .out_valid (yaw_vo),
    .out_ready (pit_ri),
    .out_word  (yaw_out)
  );

  // pitch: (y, yaw_z) -> (pit_y, pit_z), yaw_x rides along
  always_comb begin
    pit_in.id   = yaw_out.id;
    pit_in.a    = yaw_out.side;
    pit_in.b    = yaw_out.a;
    pit_in.side = yaw_out.b;
  end

  evp_rotate u_pitch (
    .clk, .rst_n,
    .in_valid  (yaw_vo),
    .in_ready  (pit_ri),
    .in_word   (pit_in),
    .trig_i    (trig[AX_PITCH]),
    .out_valid (pit_vo),
    .out_ready (rol_ri),
    .out_word  (pit_out)
  );

  // roll: (yaw_x, pit_y) -> (rol_x, rol_y), pit_z rides along as depth
  always_comb begin
    rol_in.id   = pit_out.id;
    rol_in.a    = pit_out.side;
    rol_in.b    = pit_out.a;
    rol_in.side = pit_out.b;
  end

  evp_rotate u_roll (
    .clk, .rst_n,
    .in_valid  (pit_vo),
    .in_ready  (rol_ri),
    .in_word   (rol_in),
    .trig_i    (trig[AX_ROLL]),
    .out_valid (rol_vo),
    .out_ready (prj_ri),
    .out_word  (rol_out)
  );

  evp_project u_project (
    .clk, .rst_n,
    .in_valid  (rol_vo),
    .in_ready  (prj_ri),
    .in_word   (rol_out),
    .zoom      (zoom),
    .offx      (offx),
    .offy      (offy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_id    (res_id),
    .out_px    (res_px),
    .out_py    (res_py),
    .out_depth (res_depth)
  );

  assign out_tdata = TDATA_W'({res_depth, res_py, res_px, res_id});

endmodule

// ===== tb/euler_rotate_project_vertex_unit_tb.sv =====
// Testbench for euler_rotate_project_vertex_unit: vertices in, projected vertices out.
// A directed table runs first, then random config phases. Words are checked against
// typed table words or the bench predictor. Needs evp_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module euler_rotate_project_vertex_unit_tb;
  import evp_pkg::*;

  localparam int CLK_LIMIT      = 200000;
  localparam int MAX_IDLE       = 18;
  localparam int HOLD_OFF       = 400;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_VERTICES = 50;
  localparam int SETTLE_CYCLES  = 16;
  localparam int REG_STRIDE     = 4;
  localparam int REG_SPARE_LO   = NUM_REGS;
  localparam int REG_SPARE_HI   = NUM_REGS + 1;
  localparam int SC_FRAC        = 16;   // sine / cosine fraction bits
  localparam int ZM_FRAC        = 16;
  localparam int ANG_FRAC       = 14;   // CORDIC 30 bits down to SC_FRAC
  localparam int ANG_STEPS      = 20;
  localparam longint ANG_GAIN   = 652032874;
  localparam longint SC_ONE     = 65536;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_in_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] depth;
  } vertex_out_t;

  typedef struct packed {
    bit          is_cfg;
    int          reg_sel;
    logic [31:0] reg_val;
    vertex_in_t  vtx;
    bit          typed;
    vertex_out_t want;
  } script_row_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic [TDATA_W-1:0]   in_tdata    = '0;
  logic                 out_tready  = 1'b0;
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr   = '0;
  logic [CFG_DW-1:0]    cfg_pwdata  = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [TDATA_W-1:0]   out_tdata;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  // bench copy of the block's state
  longint      trig_cs [6];
  longint      zoom_q;
  longint      off_x;
  longint      off_y;
  vertex_out_t expected_q [$];
  script_row_t script [$];
  int          errors     = 0;
  int          cycles     = 0;
  int          sent_count = 0;
  bit          send_quiet = 1'b0;

  euler_rotate_project_vertex_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // vertex_id, pos_x, pos_y, pos_z
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // out_id, page_x, page_y, depth
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint atan_step(int i);
    longint v;
    case (i)
      0:       v = 536870912;
      1:       v = 316933406;
      2:       v = 167458907;
      3:       v = 85004756;
      4:       v = 42667331;
      5:       v = 21354465;
      6:       v = 10679838;
      7:       v = 5340245;
      8:       v = 2670163;
      9:       v = 1335087;
      10:      v = 667544;
      11:      v = 333772;
      12:      v = 166886;
      13:      v = 83443;
      14:      v = 41722;
      15:      v = 20861;
      16:      v = 10430;
      17:      v = 5215;
      18:      v = 2608;
      default: v = 1304;
    endcase
    return v;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint trig_q(longint v);
    longint r;
    r = round_shift(v, ANG_FRAC);
    if (r > SC_ONE) r = SC_ONE;
    if (r < -SC_ONE) r = -SC_ONE;
    return r;
  endfunction

  function automatic logic [31:0] clamp_coord(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (v < -longint'(64'h8000_0000)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // cos / sin of a 16 bit turn fraction into trig_cs[slot], trig_cs[slot+1]
  function automatic void load_angle(logic [15:0] ang, int slot);
    logic [31:0] bam;
    longint      x, y, z, dx, dy, c, s, t;
    bam = {ang, 16'h0000};
    z   = {34'b0, bam[29:0]};
    if (z == 0) begin
      c = SC_ONE;
      s = 0;
    end else begin
      x = ANG_GAIN;
      y = 0;
      for (int i = 0; i < ANG_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_step(i);
        end else begin
          x = x + dx; y = y - dy; z = z + atan_step(i);
        end
      end
      c = trig_q(x);
      s = trig_q(y);
    end
    case (bam[31:30])
      2'd1: begin t = c; c = -s; s = t; end
      2'd2: begin c = -c; s = -s; end
      2'd3: begin t = c; c = s; s = -t; end
      default: ;
    endcase
    trig_cs[slot]     = c;
    trig_cs[slot + 1] = s;
  endfunction

  function automatic void apply_reg(int sel, logic [31:0] val);
    case (sel)
      REG_YAW:   load_angle(val[15:0], 0);
      REG_PITCH: load_angle(val[15:0], 2);
      REG_ROLL:  load_angle(val[15:0], 4);
      REG_ZOOM:  zoom_q = {40'b0, val[23:0]};
      REG_OFFX:  off_x = longint'($signed(val));
      REG_OFFY:  off_y = longint'($signed(val));
      default: ;   // holes in the map are ignored
    endcase
  endfunction

  function automatic vertex_out_t project_vertex(vertex_in_t v);
    longint      x, y, z, yaw_x, yaw_z, pit_y, pit_z, rol_x, rol_y;
    vertex_out_t r;
    x = longint'($signed(v.x));
    y = longint'($signed(v.y));
    z = longint'($signed(v.z));
    yaw_x = round_shift(x * trig_cs[0] + z * trig_cs[1], SC_FRAC);
    yaw_z = round_shift(z * trig_cs[0] - x * trig_cs[1], SC_FRAC);
    pit_y = round_shift(y * trig_cs[2] - yaw_z * trig_cs[3], SC_FRAC);
    pit_z = round_shift(y * trig_cs[3] + yaw_z * trig_cs[2], SC_FRAC);
    rol_x = round_shift(yaw_x * trig_cs[4] - pit_y * trig_cs[5], SC_FRAC);
    rol_y = round_shift(yaw_x * trig_cs[5] + pit_y * trig_cs[4], SC_FRAC);
    r.id    = v.id;
    r.px    = clamp_coord(off_x + round_shift(rol_x * zoom_q, ZM_FRAC));
    r.py    = clamp_coord(off_y + round_shift(rol_y * zoom_q, ZM_FRAC));
    r.depth = clamp_coord(pit_z);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0: r = $urandom();
      1: r = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: begin
        case ($urandom_range(0, 3))
          0:       r = 32'h7FFF_FFFF;
          1:       r = 32'h8000_0000;
          2:       r = 32'hFFFF_FFFF;
          default: r = 32'h0000_0000;
        endcase
      end
      default: r = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endcase
    return r;
  endfunction

  function automatic script_row_t cfg_row(int sel, logic [31:0] val);
    script_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  // typed rows carry their expected word, the rest go through the predictor
  function automatic script_row_t vtx_row(bit typed, logic [31:0] id, logic [31:0] x,
                                          logic [31:0] y, logic [31:0] z, logic [31:0] px,
                                          logic [31:0] py, logic [31:0] depth);
    script_row_t r;
    r = '0;
    r.vtx.id     = id;
    r.vtx.x      = x;
    r.vtx.y      = y;
    r.vtx.z      = z;
    r.typed      = typed;
    r.want.id    = id;
    r.want.px    = px;
    r.want.py    = py;
    r.want.depth = depth;
    return r;
  endfunction

  function automatic void add_row(script_row_t r);
    script.insert(script.size(), r);
  endfunction

  function automatic void queue_want(vertex_out_t w);
    expected_q.insert(expected_q.size(), w);
  endfunction

  task automatic cfg_write(int sel, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(sel * REG_STRIDE);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    apply_reg(sel, val);
    @(posedge clk);
  endtask

  task automatic send_vertex(vertex_in_t v, bit typed, vertex_out_t want);
    int gap;
    if (sent_count % 40 == 0) send_quiet = ($urandom_range(0, 2) == 0);
    sent_count++;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v.z, v.y, v.x, v.id};
    do @(posedge clk); while (!in_tready);
    queue_want(typed ? want : project_vertex(v));
  endtask

  // registers only change with the pipe empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    vertex_in_t  v;
    logic [31:0] val;

    for (int i = 0; i < 6; i += 2) begin
      trig_cs[i]     = SC_ONE;
      trig_cs[i + 1] = 0;
    end
    zoom_q = 65536;
    off_x  = 0;
    off_y  = 0;

    // identity transform out of reset: words come back as sent
    add_row(vtx_row(1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    add_row(vtx_row(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    add_row(vtx_row(1, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    add_row(vtx_row(1, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_8000,
                    32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_8000));
    // max zoom and extreme offsets: page saturates both ways
    add_row(cfg_row(REG_ZOOM, 32'h00FF_FFFF));
    add_row(cfg_row(REG_OFFX, 32'h7FFF_FFFF));
    add_row(cfg_row(REG_OFFY, 32'h8000_0000));
    add_row(vtx_row(1, 32'h2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678));
    add_row(vtx_row(1, 32'h3, 32'h0, 32'h0, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    // zoom high bits are dropped, leaving zero zoom: page is the offset
    add_row(cfg_row(REG_ZOOM, 32'hFF00_0000));
    add_row(vtx_row(1, 32'h4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h5));
    // writes past the last register must not land anywhere
    add_row(cfg_row(REG_SPARE_LO, 32'h0000_1234));
    add_row(cfg_row(REG_SPARE_HI, 32'hFFFF_FFFF));
    add_row(cfg_row(REG_OFFX, 32'h0));
    add_row(cfg_row(REG_OFFY, 32'h0));
    add_row(cfg_row(REG_ZOOM, 32'h0001_0000));
    add_row(vtx_row(1, 32'hDEAD_BEEF, 32'hFFFF_FFFB, 32'h3, 32'hFFFF_FFF9,
                    32'hFFFF_FFFB, 32'h3, 32'hFFFF_FFF9));
    // exact quadrant angles
    add_row(cfg_row(REG_YAW, 32'h4000));
    add_row(cfg_row(REG_PITCH, 32'h8000));
    add_row(cfg_row(REG_ROLL, 32'hC000));
    add_row(vtx_row(0, 32'h10, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0));
    add_row(vtx_row(0, 32'h11, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    add_row(vtx_row(0, 32'h12, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    // eighth turns with junk above the angle; last row pushes depth past range
    add_row(cfg_row(REG_YAW, 32'hFFFF_2000));
    add_row(cfg_row(REG_PITCH, 32'h2000));
    add_row(cfg_row(REG_ROLL, 32'h6000));
    add_row(vtx_row(0, 32'h20, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    add_row(vtx_row(0, 32'h21, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    add_row(vtx_row(0, 32'h22, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
    add_row(vtx_row(0, 32'h23, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    // smallest and largest angle steps, 128x zoom, offsets
    add_row(cfg_row(REG_YAW, 32'hFFFF));
    add_row(cfg_row(REG_PITCH, 32'h0001));
    add_row(cfg_row(REG_ROLL, 32'h7FFF));
    add_row(cfg_row(REG_ZOOM, 32'h0080_0000));
    add_row(cfg_row(REG_OFFX, 32'hF000_0000));
    add_row(cfg_row(REG_OFFY, 32'h1000_0000));
    add_row(vtx_row(0, 32'h30, 32'h1234_5678, 32'hEDCB_A988, 32'h00C0_FFEE, 0, 0, 0));
    add_row(vtx_row(0, 32'h31, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 0, 0, 0));
    add_row(vtx_row(0, 32'h32, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_idle();
        cfg_write(script[i].reg_sel, script[i].reg_val);
      end else begin
        send_vertex(script[i].vtx, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      for (int sel = 0; sel <= REG_SPARE_HI; sel++) begin
        if ($urandom_range(0, 1) == 1) begin
          val = $urandom();
          case (sel)
            REG_YAW, REG_PITCH, REG_ROLL: begin
              case ($urandom_range(0, 4))
                0:       val[15:0] = 16'h0000;
                1:       val[15:0] = {2'($urandom_range(0, 3)), 14'h0};
                2:       val[15:0] = 16'hFFFF;
                3:       val[15:0] = 16'h0001;
                default: ;
              endcase
            end
            REG_ZOOM: begin
              case ($urandom_range(0, 4))
                0:       val = 32'h0;
                1:       val = 32'h00FF_FFFF;
                2:       val = 32'h0001_0000;
                3:       val = $urandom_range(0, 32'h0003_FFFF);
                default: ;
              endcase
            end
            REG_OFFX, REG_OFFY: val = pick_coord();
            default: ;
          endcase
          cfg_write(sel, val);
        end
      end
      for (int k = 0; k < PHASE_VERTICES; k++) begin
        v.id = $urandom();
        v.x  = pick_coord();
        v.y  = pick_coord();
        v.z  = pick_coord();
        send_vertex(v, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("euler_rotate_project_vertex_unit regression: pass");
    end else begin
      $display("euler_rotate_project_vertex_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int  stall;
    int  taken;
    bit  quiet;
    taken = 0;
    quiet = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      // long hold-off so the pipe fills and backs up into in_tready
      if (taken == 150 || taken == 380) stall = HOLD_OFF;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_out
    vertex_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: out word with no vertex pending, expected none, got %h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_id", want.id, out_tdata[31:0]);
        check_field("page_x", want.px, out_tdata[63:32]);
        check_field("page_y", want.py, out_tdata[95:64]);
        check_field("depth", want.depth, out_tdata[127:96]);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CLK_LIMIT) begin
      $display("euler_rotate_project_vertex_unit regression: fail");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/evp_pkg.sv
hdl/evp_regs.sv
hdl/evp_trig.sv
hdl/evp_rotate.sv
hdl/evp_project.sv
hdl/euler_rotate_project_vertex_unit.sv
tb/euler_rotate_project_vertex_unit_tb.sv
